### sv/rssi_parent_table_select_defines.svh
// ---------------------------------------------------------------------------
// Parent table select assertion macros
// Shared assertion forms for the checker of the parent table block.
// ---------------------------------------------------------------------------
`ifndef RSSI_PARENT_TABLE_SELECT_DEFINES_SVH
`define RSSI_PARENT_TABLE_SELECT_DEFINES_SVH

// Assertion that is switched off while reset is high.
`define RPTS_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("parent table select: assertion failed");

// Assertion that is also checked during reset.
`define RPTS_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("parent table select: assertion failed");

`endif

### sv/rpts_pkg.sv
// ---------------------------------------------------------------------------
// Parent table select package
// Widths, codes and the types shared by the controller and the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package rpts_pkg;

   localparam int TABLE_ENTRIES_DEF = 8;
   localparam int ID_W              = 16;
   localparam int METRIC_W          = 16;
   localparam int RSSI_W            = 8;
   localparam int REQ_DATA_W        = 40;
   localparam int RSP_DATA_W        = 40;
   localparam int RSP_FIELDS_W      = 1 + ID_W + METRIC_W;

   localparam logic signed [METRIC_W-1:0] UNKNOWN_METRIC_RESET = 16'sh8000;
   localparam logic signed [METRIC_W-1:0] METRIC_MAX           = 16'sh7FFF;
   localparam logic signed [METRIC_W-1:0] METRIC_MIN           = 16'sh8000;

   localparam logic CSR_IS_ROOT        = 1'b0;
   localparam logic CSR_UNKNOWN_METRIC = 1'b1;

   typedef enum logic [1:0] {
      OUTCOME_UPDATED  = 2'd0,
      OUTCOME_INSERTED = 2'd1,
      OUTCOME_DROPPED  = 2'd2,
      OUTCOME_IGNORED  = 2'd3
   } outcome_type;

   typedef struct packed {
      logic [ID_W-1:0]            id;
      logic signed [METRIC_W-1:0] metric;
   } entry_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_done;
   } dp_status_type;

endpackage

`default_nettype wire

### sv/rpts_ctrl.sv
// ---------------------------------------------------------------------------
// Parent table select controller
// Sequences beacon capture, the table scan, the commit and the response.
// ---------------------------------------------------------------------------
`default_nettype none

module rpts_ctrl
   import rpts_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   output ctrl_cmd_type       cmd,
   input  wire dp_status_type status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      slot_free;

   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.load   = req_tready && req_tvalid;
   assign cmd.scan   = (state_ff == ST_SCAN);
   assign cmd.commit = (state_ff == ST_COMMIT) && slot_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_SCAN;
               end
            end
            ST_SCAN: begin
               if (status.scan_done) begin
                  state_ff <= ST_COMMIT;
               end
            end
            ST_COMMIT: begin
               if (slot_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

### sv/rpts_datapath.sv
// ---------------------------------------------------------------------------
// Parent table select datapath
// Holds the neighbour table memory, the scan pipeline, the selection and
// the response register.
// ---------------------------------------------------------------------------
`default_nettype none

module rpts_datapath
   import rpts_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_we,
   input  wire logic                       csr_addr,
   input  wire logic [METRIC_W-1:0]        csr_wdata,
   input  wire logic [ID_W-1:0]            neighbor_id,
   input  wire logic signed [METRIC_W-1:0] advertised_metric,
   input  wire logic signed [RSSI_W-1:0]   link_rssi,
   input  wire ctrl_cmd_type               cmd,
   output dp_status_type                   status,
   output outcome_type                     outcome,
   output logic                            parent_valid,
   output logic [ID_W-1:0]                 parent_id,
   output logic signed [METRIC_W-1:0]      own_metric
);

   localparam int CW   = $clog2(TABLE_ENTRIES + 1);
   localparam int IDXW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   entry_type mem [TABLE_ENTRIES];
   entry_type rd_entry_ff;

   logic                       is_root_ff;
   logic signed [METRIC_W-1:0] unknown_metric_ff;

   logic [ID_W-1:0]            id_ff;
   logic signed [METRIC_W-1:0] sum_ff;
   logic signed [METRIC_W:0]   sum_wide;
   logic signed [METRIC_W-1:0] sum_sat;

   logic [CW-1:0]              count_ff;
   logic [CW-1:0]              scan_idx_ff;
   logic                       pend_ff;
   logic [IDXW-1:0]            pend_idx_ff;
   logic                       issue;

   logic                       found_ff,  found_in;
   logic [IDXW-1:0]            match_ff,  match_in;
   logic                       best_v_ff, best_v_in;
   logic signed [METRIC_W-1:0] best_ff,   best_in;
   logic [ID_W-1:0]            best_id_ff, best_id_in;
   logic                       hit;
   logic signed [METRIC_W-1:0] cand;

   logic                       chosen_valid_ff, chosen_valid_in;
   logic [ID_W-1:0]            chosen_id_ff,    chosen_id_in;
   logic signed [METRIC_W-1:0] chosen_metric_ff, chosen_metric_in;
   outcome_type                outcome_in;
   logic                       wr_en;
   logic [IDXW-1:0]            wr_idx;
   logic signed [METRIC_W-1:0] own_in;

   outcome_type                outcome_ff;
   logic                       parent_valid_ff;
   logic [ID_W-1:0]            parent_id_ff;
   logic signed [METRIC_W-1:0] own_metric_ff;

   assign sum_wide = {advertised_metric[METRIC_W-1], advertised_metric}
                   + {{(METRIC_W + 1 - RSSI_W){link_rssi[RSSI_W-1]}}, link_rssi};

   always_comb begin
      if (sum_wide[METRIC_W] != sum_wide[METRIC_W-1]) begin
         sum_sat = sum_wide[METRIC_W] ? METRIC_MIN : METRIC_MAX;
      end else begin
         sum_sat = sum_wide[METRIC_W-1:0];
      end
   end

   assign issue            = cmd.scan && (scan_idx_ff < count_ff);
   assign status.scan_done = !issue && !pend_ff;

   // The entry being updated is judged by the new sum; all other entries
   // keep their stored metric.
   assign hit  = pend_ff && (rd_entry_ff.id == id_ff);
   assign cand = hit ? sum_ff : rd_entry_ff.metric;

   always_comb begin
      found_in   = found_ff;
      match_in   = match_ff;
      best_v_in  = best_v_ff;
      best_in    = best_ff;
      best_id_in = best_id_ff;
      if (cmd.load) begin
         found_in  = 1'b0;
         best_v_in = 1'b0;
      end else if (pend_ff) begin
         if (hit && !found_ff) begin
            found_in = 1'b1;
            match_in = pend_idx_ff;
         end
         if (!best_v_ff || (cand >= best_ff)) begin
            best_v_in  = 1'b1;
            best_in    = cand;
            best_id_in = rd_entry_ff.id;
         end
      end
   end

   always_comb begin
      chosen_valid_in  = chosen_valid_ff;
      chosen_id_in     = chosen_id_ff;
      chosen_metric_in = chosen_metric_ff;
      wr_en            = 1'b0;
      wr_idx           = match_ff;
      if (is_root_ff) begin
         outcome_in = OUTCOME_IGNORED;
      end else if (found_ff) begin
         outcome_in       = OUTCOME_UPDATED;
         wr_en            = 1'b1;
         chosen_valid_in  = 1'b1;
         chosen_id_in     = best_id_ff;
         chosen_metric_in = best_ff;
      end else if (count_ff < CW'(TABLE_ENTRIES)) begin
         outcome_in      = OUTCOME_INSERTED;
         wr_en           = 1'b1;
         wr_idx          = count_ff[IDXW-1:0];
         chosen_valid_in = 1'b1;
         if (!best_v_ff || (sum_ff >= best_ff)) begin
            chosen_id_in     = id_ff;
            chosen_metric_in = sum_ff;
         end else begin
            chosen_id_in     = best_id_ff;
            chosen_metric_in = best_ff;
         end
      end else begin
         outcome_in = OUTCOME_DROPPED;
      end

      if (is_root_ff) begin
         own_in = '0;
      end else if (chosen_valid_in) begin
         own_in = chosen_metric_in;
      end else begin
         own_in = unknown_metric_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         rd_entry_ff <= mem[scan_idx_ff[IDXW-1:0]];
      end
      if (cmd.commit && wr_en) begin
         mem[wr_idx] <= '{id: id_ff, metric: sum_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         id_ff  <= neighbor_id;
         sum_ff <= sum_sat;
      end
      pend_idx_ff <= scan_idx_ff[IDXW-1:0];
      match_ff    <= match_in;
      best_ff     <= best_in;
      best_id_ff  <= best_id_in;
      if (cmd.commit) begin
         outcome_ff      <= outcome_in;
         parent_valid_ff <= chosen_valid_in;
         parent_id_ff    <= chosen_id_in;
         own_metric_ff   <= own_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_root_ff        <= 1'b0;
         unknown_metric_ff <= UNKNOWN_METRIC_RESET;
         count_ff          <= '0;
         scan_idx_ff       <= '0;
         pend_ff           <= 1'b0;
         found_ff          <= 1'b0;
         best_v_ff         <= 1'b0;
         chosen_valid_ff   <= 1'b0;
         chosen_id_ff      <= '0;
         chosen_metric_ff  <= '0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_IS_ROOT:        is_root_ff        <= csr_wdata[0];
               CSR_UNKNOWN_METRIC: unknown_metric_ff <= csr_wdata;
               default:            is_root_ff        <= is_root_ff;
            endcase
         end
         found_ff  <= found_in;
         best_v_ff <= best_v_in;
         pend_ff   <= issue;
         if (cmd.load) begin
            scan_idx_ff <= '0;
         end else if (issue) begin
            scan_idx_ff <= scan_idx_ff + CW'(1);
         end
         if (cmd.commit) begin
            chosen_valid_ff  <= chosen_valid_in;
            chosen_id_ff     <= chosen_id_in;
            chosen_metric_ff <= chosen_metric_in;
            if (outcome_in == OUTCOME_INSERTED) begin
               count_ff <= count_ff + CW'(1);
            end
         end
      end
   end

   assign outcome      = outcome_ff;
   assign parent_valid = parent_valid_ff;
   assign parent_id    = parent_id_ff;
   assign own_metric   = own_metric_ff;

endmodule

`default_nettype wire

### sv/rssi_parent_table_select.sv
// ---------------------------------------------------------------------------
// RSSI parent table select
// Keeps a table of candidate parents fed by received beacons and reports
// the preferred parent and the node's own metric after each beacon.
// ---------------------------------------------------------------------------
// Each beacon transfer produces exactly one response transfer. The table is
// scanned through its single read port: the reads of the stored entries are
// issued one after another, the last read is compared, the scan is seen to
// finish, and then the commit writes the response to the output register. The
// next beacon is taken after the commit, once the response has been written to
// the output register, even if it has not yet been taken. A response that is
// still waiting holds the commit of the following beacon.
`default_nettype none

module rssi_parent_table_select
   import rpts_pkg::*;
#(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_addr,
   input  wire logic [METRIC_W-1:0]   csr_wdata,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // neighbor_id [15:0], advertised_metric [31:16], link_rssi [39:32]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // parent_valid [0], parent_id [16:1], own_metric [32:17], zero above
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // outcome [1:0]
   output logic [1:0]                 rsp_tuser
);

   ctrl_cmd_type               cmd;
   dp_status_type              status;
   outcome_type                outcome;
   logic                       parent_valid;
   logic [ID_W-1:0]            parent_id;
   logic signed [METRIC_W-1:0] own_metric;

   rpts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   rpts_datapath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_addr          (csr_addr),
      .csr_wdata         (csr_wdata),
      .neighbor_id       (req_tdata[ID_W-1:0]),
      .advertised_metric (req_tdata[ID_W+METRIC_W-1:ID_W]),
      .link_rssi         (req_tdata[ID_W+METRIC_W+RSSI_W-1:ID_W+METRIC_W]),
      .cmd               (cmd),
      .status            (status),
      .outcome           (outcome),
      .parent_valid      (parent_valid),
      .parent_id         (parent_id),
      .own_metric        (own_metric)
   );

   assign rsp_tdata = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, own_metric, parent_id,
                       parent_valid};
   assign rsp_tuser = outcome;

endmodule

`default_nettype wire

### sv/rpts_checker.sv
// ---------------------------------------------------------------------------
// Parent table select checker
// Port-level checks on the response stream, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "rssi_parent_table_select_defines.svh"

module rpts_checker
   import rpts_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [1:0]            rsp_tuser
);

   logic                rsp_parent_valid;
   logic [ID_W-1:0]     rsp_parent_id;
   logic [METRIC_W-1:0] rsp_own_metric;
   logic                root_rsp;
   logic                no_parent_rsp;
   logic                change_rsp;

   assign rsp_parent_valid = rsp_tdata[0];
   assign rsp_parent_id    = rsp_tdata[ID_W:1];
   assign rsp_own_metric   = rsp_tdata[RSP_FIELDS_W-1:ID_W+1];
   assign root_rsp         = rsp_tvalid && (rsp_tuser == OUTCOME_IGNORED);
   assign no_parent_rsp    = rsp_tvalid && !rsp_parent_valid;
   assign change_rsp       = rsp_tvalid &&
                             (rsp_tuser inside {OUTCOME_UPDATED, OUTCOME_INSERTED});

   `RPTS_ASSERT_ALWAYS(a_no_rsp_after_reset, clock, $past(reset) |-> !rsp_tvalid)
   `RPTS_ASSERT(a_rsp_held, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   `RPTS_ASSERT(a_root_metric_zero, clock, reset, root_rsp |-> rsp_own_metric == '0)
   `RPTS_ASSERT(a_no_parent_id, clock, reset, no_parent_rsp |-> rsp_parent_id == '0)
   `RPTS_ASSERT(a_parent_after_change, clock, reset, change_rsp |-> rsp_parent_valid)

endmodule

bind rssi_parent_table_select rpts_checker u_rpts_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
